// File: rtl/brl_pkg.sv
// Shared types and constants for the line rasterizer.
package brl_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Item operation codes carried on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // Slope class used to fold a line into the first octant
    typedef enum logic [1:0] {
        MC_FLAT  = 2'd0,   // slope 0..1
        MC_STEEP = 2'd1,   // slope above 1 or vertical up
        MC_FALL  = 2'd2,   // slope -1..0, not 0
        MC_OTHER = 2'd3    // slope below -1, vertical down, single point
    } t_mirror;

endpackage

// File: rtl/brl_classify.sv
// Slope classifier: picks the octant fold from the endpoint differences.
module brl_classify import brl_pkg::*; #(
    parameter int DW = COORD_BITS_DEF + 1
) (
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    output t_mirror              o_class
);

    logic signed [DW:0] w_dx;
    logic signed [DW:0] w_dy;
    logic signed [DW:0] w_ndx;

    assign w_dx  = (DW+1)'(i_dx);
    assign w_dy  = (DW+1)'(i_dy);
    assign w_ndx = -w_dx;

    always_comb begin
        if (w_dx == '0) begin
            o_class = (w_dy > 0) ? MC_STEEP : MC_OTHER;
        end else if (w_dx > 0) begin
            if (w_dy >= 0 && w_dy <= w_dx) begin
                o_class = MC_FLAT;
            end else if (w_dy > w_dx) begin
                o_class = MC_STEEP;
            end else if (w_dy < 0 && w_dy >= w_ndx) begin
                o_class = MC_FALL;
            end else begin
                o_class = MC_OTHER;
            end
        end else begin
            if (w_dy <= 0 && w_dy >= w_dx) begin
                o_class = MC_FLAT;
            end else if (w_dy < w_dx) begin
                o_class = MC_STEEP;
            end else if (w_dy > 0 && w_dy <= w_ndx) begin
                o_class = MC_FALL;
            end else begin
                o_class = MC_OTHER;
            end
        end
    end

endmodule

// File: rtl/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer core with octant folding.
//
// Input stream (s_axis): tuser selects the operation. A load item carries two
// endpoints in tdata and yields the line's first pixel; a next item yields the
// following pixel. A next item after the last pixel, or with no line loaded,
// yields nothing and leaves the state alone. A load abandons any line in flight.
// Output stream (m_axis): one pixel per item that yields one, in original
// coordinates, tlast set on the line's final pixel.
//
// An accepted item passes through the input register, then one pass of
// add/compare logic into the output register. Throughput is one item per
// cycle while the output is not held, with the decision update on the walk
// registers done in one pass. While a pixel waits in the output register,
// the input side keeps accepting only while the input register is empty,
// so s_axis_tready drops once both registers fill, until the pixel is taken.
// Reset (synchronous, active low) empties both registers and unloads the line.
module bresenham_line_rasterizer_core import brl_pkg::*; #(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // start_x, start_y, finish_x, finish_y, zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    // operation
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // point_x, point_y, zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int CB = COORD_BITS;
    localparam int W  = CB + 1;    // folded coordinates
    localparam int SW = CB + 2;    // straight increment
    localparam int EW = CB + 3;    // decision and diagonal increment

    // input register
    logic                 r_in_valid;
    logic                 r_in_op;
    logic signed [CB-1:0] r_sx, r_sy, r_fx, r_fy;

    // walk state
    logic signed [W-1:0]  r_walk_x, r_walk_y, r_walk_end;
    logic signed [W-1:0]  n_walk_x, n_walk_y, n_walk_end;
    logic signed [EW-1:0] r_dec, n_dec;
    logic signed [SW-1:0] r_straight, n_straight;
    logic signed [EW-1:0] r_diag, n_diag;
    t_mirror              r_cls, n_cls;
    logic                 r_line_active, n_line_active;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [CB-1:0]        r_px, n_px, r_py, n_py;
    logic                 r_last, n_last;

    logic                 w_fire;
    logic                 w_emit;
    logic signed [W-1:0]  w_dxs, w_dys;
    t_mirror              w_cls;
    logic signed [W-1:0]  w_ax, w_ay, w_bx, w_by;
    logic signed [W-1:0]  w_m1x, w_m1y, w_m2x, w_m2y;
    logic signed [EW-1:0] w_dx_e, w_dy_e;
    logic signed [W-1:0]  w_neg_x, w_neg_y;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    // load path: classify and fold both endpoints
    assign w_ax  = W'(r_sx);
    assign w_ay  = W'(r_sy);
    assign w_bx  = W'(r_fx);
    assign w_by  = W'(r_fy);
    assign w_dxs = w_bx - w_ax;
    assign w_dys = w_by - w_ay;

    brl_classify #(
        .DW (W)
    ) u_classify (
        .i_dx    (w_dxs),
        .i_dy    (w_dys),
        .o_class (w_cls)
    );

    always_comb begin
        w_m1x = w_ax;
        w_m1y = w_ay;
        w_m2x = w_bx;
        w_m2y = w_by;
        case (w_cls)
            MC_FLAT: begin
            end
            MC_STEEP: begin
                w_m1x = w_ay;  w_m1y = w_ax;
                w_m2x = w_by;  w_m2y = w_bx;
            end
            MC_FALL: begin
                w_m1x = -w_ax;
                w_m2x = -w_bx;
            end
            MC_OTHER: begin
                w_m1x = w_ay;  w_m1y = -w_ax;
                w_m2x = w_by;  w_m2y = -w_bx;
            end
            default: begin
            end
        endcase
    end

    assign w_dx_e = (w_m1x > w_m2x) ? (EW'(w_m1x) - EW'(w_m2x)) : (EW'(w_m2x) - EW'(w_m1x));
    assign w_dy_e = (w_m1y > w_m2y) ? (EW'(w_m1y) - EW'(w_m2y)) : (EW'(w_m2y) - EW'(w_m1y));

    assign w_neg_x = -n_walk_x;
    assign w_neg_y = -n_walk_y;

    always_comb begin
        n_walk_x      = r_walk_x;
        n_walk_y      = r_walk_y;
        n_walk_end    = r_walk_end;
        n_dec         = r_dec;
        n_straight    = r_straight;
        n_diag        = r_diag;
        n_cls         = r_cls;
        n_line_active = r_line_active;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_px          = r_px;
        n_py          = r_py;
        n_last        = r_last;
        w_emit        = 1'b0;

        if (w_fire) begin
            if (r_in_op == OP_LOAD) begin
                n_cls      = w_cls;
                n_dec      = (w_dy_e <<< 1) - w_dx_e;
                n_straight = SW'(w_dy_e <<< 1);
                n_diag     = (w_dy_e - w_dx_e) <<< 1;
                // start from the endpoint with the smaller folded x
                if (w_m1x > w_m2x) begin
                    n_walk_x   = w_m2x;
                    n_walk_y   = w_m2y;
                    n_walk_end = w_m1x;
                end else begin
                    n_walk_x   = w_m1x;
                    n_walk_y   = w_m1y;
                    n_walk_end = w_m2x;
                end
                w_emit = 1'b1;
            end else if (r_line_active) begin
                n_walk_x = r_walk_x + W'(1);
                if (r_dec < 0) begin
                    n_dec = r_dec + EW'(r_straight);
                end else begin
                    n_walk_y = r_walk_y + W'(1);
                    n_dec    = r_dec + r_diag;
                end
                w_emit = 1'b1;
            end
        end

        if (w_emit) begin
            n_out_valid   = 1'b1;
            n_last        = (n_walk_x >= n_walk_end);
            n_line_active = !n_last;
            // unfold back into original coordinates
            case (n_cls)
                MC_FLAT: begin
                    n_px = n_walk_x[CB-1:0];
                    n_py = n_walk_y[CB-1:0];
                end
                MC_STEEP: begin
                    n_px = n_walk_y[CB-1:0];
                    n_py = n_walk_x[CB-1:0];
                end
                MC_FALL: begin
                    n_px = w_neg_x[CB-1:0];
                    n_py = n_walk_y[CB-1:0];
                end
                MC_OTHER: begin
                    n_px = w_neg_y[CB-1:0];
                    n_py = n_walk_x[CB-1:0];
                end
                default: begin
                    n_px = n_walk_x[CB-1:0];
                    n_py = n_walk_y[CB-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_line_active <= 1'b0;
            r_walk_x      <= '0;
            r_walk_y      <= '0;
            r_walk_end    <= '0;
            r_dec         <= '0;
            r_straight    <= '0;
            r_diag        <= '0;
            r_cls         <= MC_FLAT;
        end else begin
            r_in_valid    <= s_axis_tvalid || (r_in_valid && !w_fire);
            r_out_valid   <= n_out_valid;
            r_line_active <= n_line_active;
            r_walk_x      <= n_walk_x;
            r_walk_y      <= n_walk_y;
            r_walk_end    <= n_walk_end;
            r_dec         <= n_dec;
            r_straight    <= n_straight;
            r_diag        <= n_diag;
            r_cls         <= n_cls;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op <= s_axis_tuser;
            r_sx    <= s_axis_tdata[CB-1:0];
            r_sy    <= s_axis_tdata[2*CB-1:CB];
            r_fx    <= s_axis_tdata[3*CB-1:2*CB];
            r_fy    <= s_axis_tdata[4*CB-1:3*CB];
        end
        r_px   <= n_px;
        r_py   <= n_py;
        r_last <= n_last;
    end

    always_comb begin
        m_axis_tdata              = '0;
        m_axis_tdata[CB-1:0]      = r_px;
        m_axis_tdata[2*CB-1:CB]   = r_py;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_last;

    // a load always produces a pixel
    a_load_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == OP_LOAD) |=> r_out_valid)
        else $error("load item produced no pixel");

    // a next item with no line leaves the walk untouched
    a_idle_next_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op == OP_NEXT && !r_line_active)
        |=> ($stable(r_walk_x) && $stable(r_walk_y) && $stable(r_dec)))
        else $error("walk changed on next item without a line");

    // the final pixel unloads the line
    a_last_unloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && n_last) |=> !r_line_active)
        else $error("line still active after final pixel");

    // an active line has not reached its end column
    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_walk_x < r_walk_end))
        else $error("active walk past end column");

endmodule
